### design/posadd_pkg.sv
// Package with the posit(6,2) format constants, the decoded operand type and the decoder.
package posadd_pkg;

  localparam int POSIT_WIDTH = 6;
  localparam int EXP_BITS    = 2;
  localparam int BODY_W      = POSIT_WIDTH - 1;
  localparam int FRAC_W      = POSIT_WIDTH - 3 - EXP_BITS;
  localparam int SIG_W       = FRAC_W + 1;
  localparam int GUARD_W     = 3;
  localparam int ALIGN_W     = SIG_W + GUARD_W;
  localparam int SUM_W       = ALIGN_W + 1;
  localparam int RUN_W       = $clog2(POSIT_WIDTH + 1);
  localparam int SHIFT_W     = $clog2(ALIGN_W + 1);
  localparam int PIDX_W      = $clog2(SUM_W);
  localparam int MAX_SCALE   = (POSIT_WIDTH - 2) * (2 ** EXP_BITS);
  localparam int SCALE_W     = $clog2(MAX_SCALE + 1) + 3;
  localparam int PAT_W       = 2 + EXP_BITS + (SUM_W - 1) + (POSIT_WIDTH - 2);

  localparam logic [POSIT_WIDTH-1:0] NAR         = {1'b1, {BODY_W{1'b0}}};
  localparam logic [POSIT_WIDTH-1:0] ZERO_WORD   = '0;
  localparam logic [BODY_W-1:0]      MAXPOS_BODY = '1;
  localparam logic [BODY_W-1:0]      MINPOS_BODY = BODY_W'(1);

  typedef struct packed {
    logic                      neg;
    logic signed [SCALE_W-1:0] scale;
    logic [SIG_W-1:0]          sig;
  } unpacked_t;

  function automatic unpacked_t unpack(input logic [POSIT_WIDTH-1:0] x);
    unpacked_t                 u;
    logic [POSIT_WIDTH-1:0]    mag;
    logic [BODY_W-1:0]         body;
    logic [BODY_W-1:0]         tail;
    logic                      rbit;
    logic                      done;
    logic [RUN_W-1:0]          run;
    logic signed [SCALE_W-1:0] k;
    logic [EXP_BITS-1:0]       e;
    u.neg = x[POSIT_WIDTH-1];
    mag   = u.neg ? (~x + POSIT_WIDTH'(1)) : x;
    body  = mag[BODY_W-1:0];
    rbit  = body[BODY_W-1];
    run   = '0;
    done  = 1'b0;
    for (int i = BODY_W - 1; i >= 0; i--) begin
      if (!done && (body[i] == rbit)) begin
        run = run + RUN_W'(1);
      end else begin
        done = 1'b1;
      end
    end
    tail  = body << (run + RUN_W'(1));
    e     = tail[BODY_W-1 -: EXP_BITS];
    u.sig = {1'b1, tail[BODY_W-1-EXP_BITS -: FRAC_W]};
    k     = $signed({{(SCALE_W - RUN_W){1'b0}}, run});
    if (rbit) begin
      k = k - SCALE_W'(1);
    end else begin
      k = -k;
    end
    u.scale = (k <<< EXP_BITS) + $signed({{(SCALE_W - EXP_BITS){1'b0}}, e});
    return u;
  endfunction

endpackage

### design/posit_6_2_adder.sv
// Top level of the posit(6,2) adder: operand register, single-pass add, result register.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+----------------------
//   input   | in_valid  | in_stall  | operand_a, operand_b
//   output  | out_valid | out_stall | sum_word
//
// Each transaction passes first through the operand register and then through
// the decode, align, add and encode logic into the result register. A new
// transaction is accepted every cycle while the input is not stalled.
// Reset empties both registers; no transaction is lost or repeated.
// While the output is stalled with a result waiting, a held operand pair
// stalls the input.
module posit_6_2_adder
  import posadd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [POSIT_WIDTH-1:0] operand_a,
  input  logic [POSIT_WIDTH-1:0] operand_b,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [POSIT_WIDTH-1:0] sum_word
);

  logic                   hold_valid;
  logic [POSIT_WIDTH-1:0] hold_a;
  logic [POSIT_WIDTH-1:0] hold_b;
  logic                   advance;

  unpacked_t                 ua;
  unpacked_t                 ub;
  unpacked_t                 big;
  unpacked_t                 sml;
  logic signed [SCALE_W-1:0] diff;
  logic [SHIFT_W-1:0]        shift;
  logic [2*ALIGN_W-1:0]      wide;
  logic [ALIGN_W-1:0]        s_al;
  logic                      sticky;
  logic [SUM_W-1:0]          big_al;
  logic [SUM_W-1:0]          res;
  logic [PIDX_W-1:0]         p;
  logic [SUM_W-1:0]          norm;
  logic signed [SCALE_W-1:0] rscale;
  logic signed [SCALE_W-1:0] rk;
  logic                      rpos;
  logic [RUN_W-1:0]          rsh;
  logic [PAT_W-1:0]          pat;
  logic [PAT_W-1:0]          shifted;
  logic [BODY_W-1:0]         mag;
  logic [POSIT_WIDTH-1:0]    sum_next;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = hold_valid && !advance;

  always_comb begin
    ua = unpack(hold_a);
    ub = unpack(hold_b);
    if ((ua.scale > ub.scale) || ((ua.scale == ub.scale) && (ua.sig >= ub.sig))) begin
      big = ua;
      sml = ub;
    end else begin
      big = ub;
      sml = ua;
    end
    diff   = big.scale - sml.scale;
    shift  = (diff > ALIGN_W) ? SHIFT_W'(ALIGN_W) : diff[SHIFT_W-1:0];
    wide   = {sml.sig, {GUARD_W{1'b0}}, {ALIGN_W{1'b0}}} >> shift;
    s_al   = wide[2*ALIGN_W-1:ALIGN_W];
    sticky = |wide[ALIGN_W-1:0];
    big_al = {1'b0, big.sig, {GUARD_W{1'b0}}};
    if (big.neg == sml.neg) begin
      res = big_al + {1'b0, s_al};
    end else begin
      res = big_al - {1'b0, s_al} - SUM_W'(sticky);
    end

    p = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (res[i]) begin
        p = PIDX_W'(i);
      end
    end
    norm   = res << (PIDX_W'(SUM_W - 1) - p);
    rscale = big.scale + $signed({{(SCALE_W - PIDX_W){1'b0}}, p})
             - SCALE_W'(ALIGN_W - 1);
    rk      = rscale >>> EXP_BITS;
    rpos    = !rk[SCALE_W-1];
    rsh     = rpos ? rk[RUN_W-1:0] : ~rk[RUN_W-1:0];
    pat     = {rpos, !rpos, rscale[EXP_BITS-1:0], norm[SUM_W-2:0],
               {(POSIT_WIDTH - 2){1'b0}}};
    shifted = $signed(pat) >>> rsh;

    if (rscale > MAX_SCALE) begin
      mag = MAXPOS_BODY;
    end else if (rscale < -MAX_SCALE) begin
      mag = MINPOS_BODY;
    end else begin
      mag = shifted[PAT_W-1 -: BODY_W];
      if (mag == '0) begin
        mag = MINPOS_BODY;
      end
    end

    if ((hold_a == NAR) || (hold_b == NAR)) begin
      sum_next = NAR;
    end else if (hold_a == ZERO_WORD) begin
      sum_next = hold_b;
    end else if (hold_b == ZERO_WORD) begin
      sum_next = hold_a;
    end else if (res == '0) begin
      sum_next = ZERO_WORD;
    end else if (big.neg) begin
      sum_next = ~{1'b0, mag} + POSIT_WIDTH'(1);
    end else begin
      sum_next = {1'b0, mag};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (!in_stall) begin
        hold_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= hold_valid;
      end
    end
    if (!in_stall && in_valid) begin
      hold_a <= operand_a;
      hold_b <= operand_b;
    end
    if (advance && hold_valid) begin
      sum_word <= sum_next;
    end
  end

  a_nar_result: assert property (@(posedge clk) disable iff (rst)
    advance && hold_valid && ((hold_a == NAR) || (hold_b == NAR)) |=> sum_word == NAR)
    else $error("NaR operand did not give a NaR sum");

  a_zero_pass: assert property (@(posedge clk) disable iff (rst)
    advance && hold_valid && (hold_a == ZERO_WORD) |=> sum_word == $past(hold_b))
    else $error("Zero first operand did not pass the second operand through");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> hold_valid && out_valid && out_stall)
    else $error("Input stalled while the pipeline had room");

endmodule
